[rtl/fwt_pkg.sv]
// Flash wear tracker package: widths, opcodes, defaults and the controller state type.
// Depends on nothing; fwt_if and the tracker import it (fwt_ram does not).
package fwt_pkg;

   localparam int ENTRIES_DEF   = 2048;
   localparam int TOP_SLOTS_DEF = 10;

   localparam int OP_W   = 2;
   localparam int ADDR_W = 32;
   localparam int CNT_W  = 16;
   localparam int IDX_W  = 6;
   localparam int WORD_W = ADDR_W + 2 * CNT_W;

   localparam logic [OP_W-1:0] OP_ERASE  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
   localparam logic [OP_W-1:0] OP_REPORT = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic [ADDR_W-1:0] PAGE_MASK = 32'h0000_0FFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_RESP,
      ST_RPT_READ,
      ST_RPT_WAIT,
      ST_RPT_SCAN,
      ST_RPT_APPLY,
      ST_EMIT
   } state_type;

endpackage

[rtl/fwt_if.sv]
// Request and response channel interfaces with valid/ready handshake.
// Depends on fwt_pkg.
interface fwt_req_if;
   import fwt_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [ADDR_W-1:0] address;
   modport source (output valid, output opcode, output address, input ready);
   modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface fwt_rsp_if;
   import fwt_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic [IDX_W-1:0]  slot_index;
   logic [ADDR_W-1:0] slot_address;
   logic [CNT_W-1:0]  slot_erases;
   logic [CNT_W-1:0]  slot_writes;
   logic              last;
   modport source (output valid, output status, output slot_index, output slot_address,
                   output slot_erases, output slot_writes, output last, input ready);
   modport sink   (input valid, input status, input slot_index, input slot_address,
                   input slot_erases, input slot_writes, input last, output ready);
endinterface

[rtl/fwt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module fwt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/flash_wear_tracker_top_list.sv]
// Flash wear tracker: entry table in one RAM, persistent top list in registers.
// Erase/write: each table entry searched is read, then compared; a response word follows.
// Report: per entry read, scan slots, apply; TOP_SLOTS words out, one per cycle when ready.
// One item at a time; the next word is taken once the last response word has left.
// Synchronous reset empties the table (fill count) and zeroes the top list; no clearing pass.
module flash_wear_tracker_top_list
   import fwt_pkg::*;
#(
   parameter int ENTRIES   = fwt_pkg::ENTRIES_DEF,
   parameter int TOP_SLOTS = fwt_pkg::TOP_SLOTS_DEF
) (
   input logic       clock,
   input logic       reset,
   fwt_req_if.sink   req_chan,
   fwt_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int SW = (TOP_SLOTS > 1) ? $clog2(TOP_SLOTS) : 1;
   localparam logic [SW-1:0] SLOT_LAST = SW'(TOP_SLOTS - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(ENTRIES);

   state_type state_ff, state_in;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     used_ff, used_in;
   logic              status_ff, status_in;
   logic [ADDR_W-1:0] ent_key_ff, ent_key_in;
   logic [CNT_W-1:0]  ent_er_ff, ent_er_in;
   logic [CNT_W-1:0]  ent_wr_ff, ent_wr_in;
   logic [CNT_W-1:0]  best_ff, best_in;
   logic [SW-1:0]     pick_ff, pick_in;
   logic              pick_vld_ff, pick_vld_in;
   logic              match_ff, match_in;
   logic [SW-1:0]     midx_ff, midx_in;
   logic [SW-1:0]     slot_ff, slot_in;

   logic [ADDR_W-1:0] top_addr_ff [TOP_SLOTS];
   logic [ADDR_W-1:0] top_addr_in [TOP_SLOTS];
   logic [CNT_W-1:0]  top_er_ff   [TOP_SLOTS];
   logic [CNT_W-1:0]  top_er_in   [TOP_SLOTS];
   logic [CNT_W-1:0]  top_wr_ff   [TOP_SLOTS];
   logic [CNT_W-1:0]  top_wr_in   [TOP_SLOTS];

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [WORD_W-1:0] mem_rdata;

   logic [ADDR_W-1:0] rd_key;
   logic [CNT_W-1:0]  rd_er;
   logic [CNT_W-1:0]  rd_wr;
   logic [CNT_W-1:0]  lead;
   logic              req_fire;
   logic              rsp_fire;

   assign rd_key   = mem_rdata[WORD_W-1 -: ADDR_W];
   assign rd_er    = mem_rdata[2*CNT_W-1 -: CNT_W];
   assign rd_wr    = mem_rdata[CNT_W-1:0];
   assign lead     = ent_er_ff - top_er_ff[slot_ff];
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   fwt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.opcode)
                  OP_ERASE:  state_in = ST_SEARCH;
                  OP_WRITE:  state_in = ST_SEARCH;
                  OP_REPORT: state_in = ST_RPT_READ;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_SEARCH: begin
            state_in = (idx_ff == used_ff) ? ST_RESP : ST_SEARCH_WAIT;
         end
         ST_SEARCH_WAIT: begin
            state_in = (rd_key == key_ff) ? ST_RESP : ST_SEARCH;
         end
         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         ST_RPT_READ: begin
            state_in = (idx_ff == used_ff) ? ST_EMIT : ST_RPT_WAIT;
         end
         ST_RPT_WAIT: begin
            state_in = ST_RPT_SCAN;
         end
         ST_RPT_SCAN: begin
            if (slot_ff == SLOT_LAST) begin
               state_in = ST_RPT_APPLY;
            end
         end
         ST_RPT_APPLY: begin
            state_in = ST_RPT_READ;
         end
         ST_EMIT: begin
            if (rsp_fire && slot_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in       = op_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      used_in     = used_ff;
      status_in   = status_ff;
      ent_key_in  = ent_key_ff;
      ent_er_in   = ent_er_ff;
      ent_wr_in   = ent_wr_ff;
      best_in     = best_ff;
      pick_in     = pick_ff;
      pick_vld_in = pick_vld_ff;
      match_in    = match_ff;
      midx_in     = midx_ff;
      slot_in     = slot_ff;
      top_addr_in = top_addr_ff;
      top_er_in   = top_er_ff;
      top_wr_in   = top_wr_ff;
      mem_we      = 1'b0;
      mem_waddr   = idx_ff[AW-1:0];
      mem_wdata   = mem_rdata;
      mem_raddr   = idx_ff[AW-1:0];

      rsp_chan.valid        = 1'b0;
      rsp_chan.status       = STATUS_OK;
      rsp_chan.slot_index   = '0;
      rsp_chan.slot_address = '0;
      rsp_chan.slot_erases  = '0;
      rsp_chan.slot_writes  = '0;
      rsp_chan.last         = 1'b1;
      req_chan.ready        = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_chan.opcode;
               idx_in    = '0;
               status_in = STATUS_OK;
               key_in    = (req_chan.opcode == OP_WRITE) ? (req_chan.address & ~PAGE_MASK)
                                                         : req_chan.address;
            end
         end
         ST_SEARCH: begin
            if (idx_ff == used_ff && op_ff == OP_ERASE) begin
               if (used_ff == FULL_CNT) begin
                  status_in = STATUS_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = used_ff[AW-1:0];
                  mem_wdata = {key_ff, CNT_W'(1), CNT_W'(0)};
                  used_in   = used_ff + CW'(1);
               end
            end
         end
         ST_SEARCH_WAIT: begin
            if (rd_key == key_ff) begin
               mem_we = 1'b1;
               if (op_ff == OP_ERASE) begin
                  mem_wdata = {rd_key, rd_er + CNT_W'(1), rd_wr};
               end else begin
                  mem_wdata = {rd_key, rd_er, rd_wr + CNT_W'(1)};
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_RESP: begin
            rsp_chan.valid  = 1'b1;
            rsp_chan.status = status_ff;
         end
         ST_RPT_READ: begin
            slot_in = '0;
         end
         ST_RPT_WAIT: begin
            ent_key_in  = rd_key;
            ent_er_in   = rd_er;
            ent_wr_in   = rd_wr;
            best_in     = '0;
            pick_vld_in = 1'b0;
            match_in    = 1'b0;
         end
         ST_RPT_SCAN: begin
            if (ent_er_ff > top_er_ff[slot_ff] && lead > best_ff) begin
               best_in     = lead;
               pick_in     = slot_ff;
               pick_vld_in = 1'b1;
            end
            if (!match_ff && top_addr_ff[slot_ff] == ent_key_ff) begin
               match_in = 1'b1;
               midx_in  = slot_ff;
            end
            if (slot_ff != SLOT_LAST) begin
               slot_in = slot_ff + SW'(1);
            end
         end
         ST_RPT_APPLY: begin
            if (pick_vld_ff) begin
               if (match_ff) begin
                  top_er_in[midx_ff] = ent_er_ff;
                  top_wr_in[midx_ff] = ent_wr_ff;
               end else begin
                  top_addr_in[pick_ff] = ent_key_ff;
                  top_er_in[pick_ff]   = ent_er_ff;
                  top_wr_in[pick_ff]   = ent_wr_ff;
               end
            end
            idx_in = idx_ff + CW'(1);
         end
         ST_EMIT: begin
            rsp_chan.valid        = 1'b1;
            rsp_chan.slot_index   = IDX_W'(slot_ff);
            rsp_chan.slot_address = top_addr_ff[slot_ff];
            rsp_chan.slot_erases  = top_er_ff[slot_ff];
            rsp_chan.slot_writes  = top_wr_ff[slot_ff];
            rsp_chan.last         = (slot_ff == SLOT_LAST);
            if (rsp_fire && slot_ff != SLOT_LAST) begin
               slot_in = slot_ff + SW'(1);
            end
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         for (int i = 0; i < TOP_SLOTS; i++) begin
            top_addr_ff[i] <= '0;
            top_er_ff[i]   <= '0;
            top_wr_ff[i]   <= '0;
         end
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         top_addr_ff <= top_addr_in;
         top_er_ff   <= top_er_in;
         top_wr_ff   <= top_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      ent_key_ff  <= ent_key_in;
      ent_er_ff   <= ent_er_in;
      ent_wr_ff   <= ent_wr_in;
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      pick_vld_ff <= pick_vld_in;
      match_ff    <= match_in;
      midx_ff     <= midx_in;
      slot_ff     <= slot_in;
   end

endmodule
